// ===== design/wta_route_exclusion_grid_macros.svh =====
// Assertion macros shared by the checker of the route exclusion grid.
`ifndef WTA_ROUTE_EXCLUSION_GRID_MACROS_SVH
`define WTA_ROUTE_EXCLUSION_GRID_MACROS_SVH

// Property checked on every clock edge while reset is released.
`define WTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define WTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/wta_pkg.sv =====
// Types and constants shared by the route exclusion grid modules.
`default_nettype none

package wta_pkg;

  // Widest city or group index the block supports.
  localparam int unsigned IdxW = 6;

  // Configuration register indexes.
  localparam logic [1:0] RegNumCities = 2'd0;
  localparam logic [1:0] RegIsoEnable = 2'd1;
  localparam logic [1:0] RegWindowEnd = 2'd2;

  // Reset value of the city count register.
  localparam logic [5:0] NumCitiesRst = 6'd26;

  // Window length in time LSBs (1.0 in 22.10 fixed point).
  localparam logic [32:0] WindowLen = 33'd1024;

  typedef enum logic [1:0] {
    KIND_SPIKE  = 2'd0,
    KIND_REFR   = 2'd1,
    KIND_MARK   = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEARED = 2'd0,
    ST_GRANTED = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  // Classified event handed from the front to the back.
  typedef struct packed {
    kind_e            kind;
    logic             grp_ok;
    logic [IdxW-1:0]  grp;
    logic [IdxW-1:0]  city;
    logic             in_win;
  } cmd_t;

  // Back status seen by the front.
  typedef struct packed {
    logic clear_busy;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== design/wta_front.sv =====
// Front end: accepts events, splits the flat index and checks the window.
`default_nettype none

module wta_front #(
  parameter int unsigned MAX_CITIES = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   push,
  output logic                                  full,
  input  wire  [1:0]                            kind_i,
  input  wire  [9:0]                            neuron_index_i,
  input  wire  [31:0]                           event_time_i,
  input  wire  [$clog2(MAX_CITIES+1)-1:0]       n_i,
  input  wire  [31:0]                           win_end_i,
  input  wta_pkg::back_stat_t                   stat_i,
  input  wire                                   q_full_i,
  output wta_pkg::cmd_t                         cmd_o,
  output logic                                  cmd_valid_o
);

  localparam int unsigned NW = $clog2(MAX_CITIES + 1);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } fstate_e;

  fstate_e           state_q;
  logic [NW:0]       rem_q, rem_d;
  logic [9:0]        num_q, num_d;
  logic [9:0]        quo_q, quo_d;
  logic [2:0]        step_q;
  logic [1:0]        kind_q;
  logic              win_q;
  logic              accept;
  logic              win_d;

  assign full   = (state_q != F_IDLE) || stat_i.clear_busy;
  assign accept = push && !full;

  // Window check: event_time + 1.0 > window_end and event_time < window_end.
  assign win_d = (({1'b0, event_time_i} + wta_pkg::WindowLen) > {1'b0, win_end_i}) &&
                 (event_time_i < win_end_i);

  // Two restoring division steps per cycle.
  always_comb begin
    logic [NW:0] r;
    logic [9:0]  d;
    logic [9:0]  q;
    r = rem_q;
    d = num_q;
    q = quo_q;
    for (int k = 0; k < 2; k++) begin
      r = {r[NW-1:0], d[9]};
      d = {d[8:0], 1'b0};
      if (r >= {1'b0, n_i}) begin
        r = r - {1'b0, n_i};
        q = {q[8:0], 1'b1};
      end else begin
        q = {q[8:0], 1'b0};
      end
    end
    rem_d = r;
    num_d = d;
    quo_d = q;
  end

  // Sequencer of the divider and the queue write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            state_q <= F_DIV;
            step_q  <= '0;
          end
        end
        F_DIV: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd4) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_q  <= '0;
      num_q  <= neuron_index_i;
      quo_q  <= '0;
      kind_q <= kind_i;
      win_q  <= win_d;
    end else if (state_q == F_DIV) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
    end
  end

  // Classified command.
  assign cmd_valid_o   = (state_q == F_PUSH);
  assign cmd_o.kind    = wta_pkg::kind_e'(kind_q);
  assign cmd_o.grp_ok  = quo_q < 10'(n_i);
  assign cmd_o.grp     = quo_q[wta_pkg::IdxW-1:0];
  assign cmd_o.city    = wta_pkg::IdxW'(rem_q);
  assign cmd_o.in_win  = win_q;

endmodule

`default_nettype wire

// ===== design/wta_cmd_fifo.sv =====
// Two-entry command queue between the front and the back.
`default_nettype none

module wta_cmd_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                wr_i,
  input  wta_pkg::cmd_t      wdata_i,
  output logic               full_o,
  input  wire                rd_i,
  output wta_pkg::cmd_t      rdata_o,
  output logic               valid_o
);

  wta_pkg::cmd_t  mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_wr;
  logic           do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= !wr_ptr_q;
      if (do_rd) rd_ptr_q <= !rd_ptr_q;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

`default_nettype wire

// ===== design/wta_back.sv =====
// Back end: route grid, cell counters, last cities and isolation grid.
`default_nettype none

module wta_back #(
  parameter int unsigned MAX_CITIES = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wta_pkg::cmd_t                      cmd_i,
  input  wire                                cmd_valid_i,
  output logic                               cmd_take_o,
  input  wire  [$clog2(MAX_CITIES+1)-1:0]    n_i,
  input  wire                                iso_en_i,
  output wta_pkg::back_stat_t                stat_o,
  output logic                               empty,
  input  wire                                pop,
  output logic [1:0]                         status_o,
  output logic [5:0]                         group_number_o,
  output logic [5:0]                         city_number_o,
  output logic [15:0]                        spike_count_o,
  output logic [5:0]                         last_city_o,
  output logic [31:0]                        iso_row_mask_o
);

  localparam int unsigned NW    = $clog2(MAX_CITIES + 1);
  localparam int unsigned GW    = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int unsigned AW    = 2 * GW;
  localparam int unsigned DEPTH = 1 << AW;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC,
    B_SETTLE,
    B_ISO,
    B_DONE
  } bstate_e;

  bstate_e                  state_q;
  wta_pkg::cmd_t            cmd_q;
  logic [1:0]               status_q;
  logic [COUNT_BITS-1:0]    res_cnt_q;
  logic [AW-1:0]            clr_q;
  logic [MAX_CITIES-1:0]    route_q [MAX_CITIES];
  logic [MAX_CITIES-1:0]    iso_q   [MAX_CITIES];
  logic [5:0]               last_q  [MAX_CITIES];
  logic [MAX_CITIES-1:0]    col_q;
  logic [MAX_CITIES-1:0]    row_has;
  logic [MAX_CITIES-1:0]    col_d;
  logic [MAX_CITIES-1:0]    mask;
  logic [COUNT_BITS-1:0]    cnt_mem [DEPTH];
  logic [COUNT_BITS-1:0]    cnt_rd_q;
  logic [COUNT_BITS-1:0]    cnt_inc;
  logic                     cnt_we;
  logic [AW-1:0]            cnt_waddr;
  logic [COUNT_BITS-1:0]    cnt_wdata;
  logic [GW-1:0]            g_idx;
  logic [GW-1:0]            c_idx;
  logic                     blocked;
  logic                     grant;
  logic [MAX_CITIES-1:0]    iso_row;

  assign g_idx = cmd_q.grp[GW-1:0];
  assign c_idx = cmd_q.city[GW-1:0];

  // Active region mask and per-row / per-column occupancy.
  always_comb begin
    for (int j = 0; j < MAX_CITIES; j++) begin
      mask[j] = NW'(j) < n_i;
    end
    col_d = '0;
    for (int r = 0; r < MAX_CITIES; r++) begin
      row_has[r] = |(route_q[r] & mask);
      if (NW'(r) < n_i) col_d = col_d | route_q[r];
    end
    col_d = col_d & mask;
  end

  // Spike decision.
  assign blocked = (|(route_q[g_idx] & mask)) || col_q[c_idx];
  assign grant   = (cmd_q.kind == wta_pkg::KIND_SPIKE) && !blocked;
  assign cnt_inc = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);

  // Counter memory write port: clearing pass or counted spike.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = {g_idx, c_idx};
    cnt_wdata = cnt_inc;
    if (state_q == B_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = '0;
    end else if (state_q == B_EXEC && cmd_q.grp_ok && grant && cmd_q.in_win) begin
      cnt_we = 1'b1;
    end
  end

  // Counter memory.
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_q <= cnt_mem[{cmd_i.grp[GW-1:0], cmd_i.city[GW-1:0]}];
  end

  assign cmd_take_o = (state_q == B_IDLE) && cmd_valid_i;

  // Sequencer with route, last-city and isolation state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      col_q   <= '0;
      for (int r = 0; r < MAX_CITIES; r++) begin
        route_q[r] <= '0;
        iso_q[r]   <= '0;
        last_q[r]  <= '0;
      end
    end else begin
      col_q <= col_d;
      unique case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == '1) state_q <= B_IDLE;
        end
        B_IDLE: begin
          if (cmd_valid_i) state_q <= B_EXEC;
        end
        B_EXEC: begin
          state_q <= B_DONE;
          if (cmd_q.grp_ok) begin
            if (cmd_q.kind == wta_pkg::KIND_REFR) begin
              route_q[g_idx][c_idx] <= 1'b0;
              state_q <= B_SETTLE;
            end else if (grant) begin
              route_q[g_idx][c_idx] <= 1'b1;
              if (cmd_q.in_win) last_q[g_idx] <= cmd_q.city + 6'd1;
              state_q <= B_SETTLE;
            end
          end
        end
        B_SETTLE: begin
          state_q <= B_ISO;
        end
        B_ISO: begin
          if (iso_en_i) begin
            for (int r = 0; r < MAX_CITIES; r++) begin
              if (NW'(r) < n_i) begin
                iso_q[r] <= (iso_q[r] & ~mask) | (row_has[r] ? mask : '0) | col_q;
              end
            end
          end
          state_q <= B_DONE;
        end
        B_DONE: begin
          if (pop) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cmd_q <= cmd_i;
    if (state_q == B_EXEC) begin
      res_cnt_q <= (grant && cmd_q.in_win) ? cnt_inc : cnt_rd_q;
      if (!cmd_q.grp_ok) begin
        status_q <= wta_pkg::ST_NONE;
      end else begin
        unique case (cmd_q.kind)
          wta_pkg::KIND_REFR:  status_q <= wta_pkg::ST_CLEARED;
          wta_pkg::KIND_SPIKE: status_q <= grant ? wta_pkg::ST_GRANTED : wta_pkg::ST_BLOCKED;
          default:             status_q <= wta_pkg::ST_NONE;
        endcase
      end
    end
  end

  assign stat_o.clear_busy = (state_q == B_CLEAR);
  assign empty             = (state_q != B_DONE);
  assign iso_row           = iso_q[g_idx];

  // Result fields; an out-of-range group reports no action and zeros in every other field.
  assign status_o       = status_q;
  assign group_number_o = cmd_q.grp_ok ? cmd_q.grp + 6'd1 : 6'd0;
  assign city_number_o  = cmd_q.grp_ok ? cmd_q.city + 6'd1 : 6'd0;
  assign last_city_o    = cmd_q.grp_ok ? last_q[g_idx] : 6'd0;

  if (COUNT_BITS >= 16) begin : g_cnt_wide
    assign spike_count_o = cmd_q.grp_ok ? res_cnt_q[15:0] : 16'd0;
  end else begin : g_cnt_narrow
    assign spike_count_o = cmd_q.grp_ok ? {{(16-COUNT_BITS){1'b0}}, res_cnt_q} : 16'd0;
  end

  if (MAX_CITIES >= 32) begin : g_iso_wide
    assign iso_row_mask_o = cmd_q.grp_ok ? iso_row[31:0] : 32'd0;
  end else begin : g_iso_narrow
    assign iso_row_mask_o = cmd_q.grp_ok ? {{(32-MAX_CITIES){1'b0}}, iso_row} : 32'd0;
  end

endmodule

`default_nettype wire

// ===== design/wta_route_exclusion_grid.sv =====
// Top level of the winner-take-all route exclusion grid.
//
//   Channel   Direction  Handshake            Payload
//   events    in         push / full          kind_i, neuron_index_i, event_time_i
//   results   out        empty / pop          status_o .. iso_row_mask_o
//   config    in         psel/penable/pready  paddr, pwdata, prdata
//
// The front splits the index with a two-bit-per-cycle divider: it accepts
// an event, runs the divider, then writes the queue once it is not full.
// The back goes from execute to done for a marker, a blocked spike or an
// out-of-range group, and through settle and isolation for a route change,
// then holds the result until it is popped. The front takes no new event
// until it has written the last one. After reset the counter memory is cleared,
// all (2^clog2(MAX_CITIES))^2 entries (1024 at the default), while full stays high.
// A two-entry queue lets the front keep accepting while a result waits.
`default_nettype none

module wta_route_exclusion_grid #(
  parameter int unsigned MAX_CITIES = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          push,
  output logic         full,
  input  wire  [1:0]   kind_i,
  input  wire  [9:0]   neuron_index_i,
  input  wire  [31:0]  event_time_i,
  output logic         empty,
  input  wire          pop,
  output logic [1:0]   status_o,
  output logic [5:0]   group_number_o,
  output logic [5:0]   city_number_o,
  output logic [15:0]  spike_count_o,
  output logic [5:0]   last_city_o,
  output logic [31:0]  iso_row_mask_o,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [3:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned NW = $clog2(MAX_CITIES + 1);

  logic [5:0]                 num_cities_q;
  logic                       iso_en_q;
  logic [31:0]                win_end_q;
  logic [NW-1:0]              n_eff;
  logic                       cfg_wr;
  wta_pkg::cmd_t              f_cmd;
  logic                       f_valid;
  wta_pkg::cmd_t              q_cmd;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_take;
  wta_pkg::back_stat_t        b_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cities_q <= wta_pkg::NumCitiesRst;
      iso_en_q     <= 1'b0;
      win_end_q    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        wta_pkg::RegNumCities: num_cities_q <= pwdata[5:0];
        wta_pkg::RegIsoEnable: iso_en_q     <= pwdata[0];
        wta_pkg::RegWindowEnd: win_end_q    <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        wta_pkg::RegNumCities: prdata = {26'd0, num_cities_q};
        wta_pkg::RegIsoEnable: prdata = {31'd0, iso_en_q};
        wta_pkg::RegWindowEnd: prdata = win_end_q;
        default:               prdata = '0;
      endcase
    end
  end

  // Effective city count, clamped to the supported range.
  always_comb begin
    if (num_cities_q < 6'd2) begin
      n_eff = NW'(2);
    end else if ({1'b0, num_cities_q} > 7'(MAX_CITIES)) begin
      n_eff = NW'(MAX_CITIES);
    end else begin
      n_eff = NW'(num_cities_q);
    end
  end

  wta_front #(
    .MAX_CITIES (MAX_CITIES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .neuron_index_i (neuron_index_i),
    .event_time_i   (event_time_i),
    .n_i            (n_eff),
    .win_end_i      (win_end_q),
    .stat_i         (b_stat),
    .q_full_i       (q_full),
    .cmd_o          (f_cmd),
    .cmd_valid_o    (f_valid)
  );

  wta_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_valid),
    .wdata_i (f_cmd),
    .full_o  (q_full),
    .rd_i    (q_take),
    .rdata_o (q_cmd),
    .valid_o (q_valid)
  );

  wta_back #(
    .MAX_CITIES (MAX_CITIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (q_cmd),
    .cmd_valid_i    (q_valid),
    .cmd_take_o     (q_take),
    .n_i            (n_eff),
    .iso_en_i       (iso_en_q),
    .stat_o         (b_stat),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .group_number_o (group_number_o),
    .city_number_o  (city_number_o),
    .spike_count_o  (spike_count_o),
    .last_city_o    (last_city_o),
    .iso_row_mask_o (iso_row_mask_o)
  );

endmodule

`default_nettype wire

// ===== design/wta_checker.sv =====
// Port-level checker for the route exclusion grid and its bind.
`default_nettype none
`include "wta_route_exclusion_grid_macros.svh"

module wta_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         full,
  input wire         empty,
  input wire         pready,
  input wire  [1:0]  status_o,
  input wire  [5:0]  group_number_o,
  input wire  [5:0]  city_number_o,
  input wire  [15:0] spike_count_o,
  input wire  [5:0]  last_city_o,
  input wire  [31:0] iso_row_mask_o
);

  // The counter clearing pass blocks input right after reset.
  `WTA_ASSERT_ALWAYS(a_full_after_reset, (rst_ni && !$past(rst_ni)) |-> full, "input open during clearing pass")

  // A result other than no action always names a group and a city.
  `WTA_ASSERT(a_acted_has_cell, (!empty && status_o != wta_pkg::ST_NONE) |-> (group_number_o != 6'd0 && city_number_o != 6'd0), "acted result without cell")

  // An out-of-range group reports no action and all-zero fields.
  `WTA_ASSERT(a_bad_group_zero, (!empty && group_number_o == 6'd0) |-> (status_o == wta_pkg::ST_NONE && city_number_o == 6'd0 && spike_count_o == 16'd0 && last_city_o == 6'd0 && iso_row_mask_o == 32'd0), "out-of-range group fields not zero")

  // The configuration port never waits.
  `WTA_ASSERT(a_pready_high, pready, "pready dropped")

endmodule

bind wta_route_exclusion_grid wta_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .full           (full),
  .empty          (empty),
  .pready         (pready),
  .status_o       (status_o),
  .group_number_o (group_number_o),
  .city_number_o  (city_number_o),
  .spike_count_o  (spike_count_o),
  .last_city_o    (last_city_o),
  .iso_row_mask_o (iso_row_mask_o)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the winner-take-all route exclusion grid.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned GridMax   = 32;
  localparam int unsigned CountMax  = 65535;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait = 24;

  // Byte addresses of the configuration registers.
  localparam logic [3:0] AddrNumCities = 4'(4 * wta_pkg::RegNumCities);
  localparam logic [3:0] AddrIsoEnable = 4'(4 * wta_pkg::RegIsoEnable);
  localparam logic [3:0] AddrWindowEnd = 4'(4 * wta_pkg::RegWindowEnd);

  typedef struct {
    wta_pkg::status_e status;
    logic [5:0]  group_num;
    logic [5:0]  city_num;
    logic [15:0] spikes;
    logic [5:0]  last_city;
    logic [31:0] iso_row;
  } grid_result_t;

  // Tracks the route grid, predicts each result and checks results in order.
  class route_scoreboard;
    logic [5:0]  num_cities;
    logic        iso_en;
    logic [31:0] win_end;
    logic [31:0] routes[GridMax];
    logic [31:0] iso[GridMax];
    logic [15:0] counts[GridMax][GridMax];
    logic [5:0]  last_city[GridMax];
    grid_result_t pending[$];
    int unsigned  mismatches;

    function new();
      num_cities = wta_pkg::NumCitiesRst;
      iso_en     = 1'b0;
      win_end    = '0;
      mismatches = 0;
      foreach (routes[g]) begin
        routes[g]    = '0;
        iso[g]       = '0;
        last_city[g] = '0;
        foreach (counts[g][c]) counts[g][c] = '0;
      end
    endfunction

    function int unsigned active_cities();
      if (num_cities < 2) return 2;
      if (num_cities > GridMax) return GridMax;
      return num_cities;
    endfunction

    // Marks every row and column of the active region that holds a route.
    function void rebuild_isolation(int unsigned n);
      logic [31:0] region;
      logic [31:0] cols;
      region = (n >= 32) ? '1 : ((32'd1 << n) - 1);
      cols   = '0;
      for (int g = 0; g < n; g++) begin
        iso[g] &= ~region;
        cols   |= routes[g] & region;
      end
      for (int g = 0; g < n; g++) begin
        if ((routes[g] & region) != 0) iso[g] |= region;
        iso[g] |= cols;
      end
    endfunction

    // Applies one accepted event to the grid and queues the expected result.
    function void note_event(wta_pkg::kind_e kind, logic [9:0] idx, logic [31:0] t);
      int unsigned  n;
      int unsigned  g;
      int unsigned  c;
      logic         blocked;
      grid_result_t res;
      n = active_cities();
      g = idx / n;
      c = idx % n;
      if (g >= n) begin
        res = '{wta_pkg::ST_NONE, '0, '0, '0, '0, '0};
        pending.push_back(res);
        return;
      end
      res.status = wta_pkg::ST_NONE;
      if (kind == wta_pkg::KIND_REFR) begin
        routes[g][c] = 1'b0;
        res.status   = wta_pkg::ST_CLEARED;
        if (iso_en) rebuild_isolation(n);
      end else if (kind == wta_pkg::KIND_SPIKE) begin
        blocked = 1'b0;
        for (int r = 0; r < n; r++) if (routes[r][c]) blocked = 1'b1;
        for (int k = 0; k < n; k++) if (routes[g][k]) blocked = 1'b1;
        if (blocked) begin
          res.status = wta_pkg::ST_BLOCKED;
        end else begin
          res.status   = wta_pkg::ST_GRANTED;
          routes[g][c] = 1'b1;
          if (({1'b0, t} + wta_pkg::WindowLen > {1'b0, win_end}) && (t < win_end)) begin
            if (counts[g][c] < CountMax) counts[g][c]++;
            last_city[g] = 6'(c + 1);
          end
          if (iso_en) rebuild_isolation(n);
        end
      end
      res.group_num = 6'(g + 1);
      res.city_num  = 6'(c + 1);
      res.spikes    = counts[g][c];
      res.last_city = last_city[g];
      res.iso_row   = iso[g];
      pending.push_back(res);
    endfunction

    // Compares one accepted result against the oldest expectation.
    function void check_result(grid_result_t got);
      grid_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no event outstanding");
        return;
      end
      exp_r = pending.pop_front();
      if (got.status != exp_r.status || got.group_num != exp_r.group_num ||
          got.city_num != exp_r.city_num || got.spikes != exp_r.spikes ||
          got.last_city != exp_r.last_city || got.iso_row != exp_r.iso_row) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected st=%0d g=%0d c=%0d cnt=%0d last=%0d iso=%h, got st=%0d g=%0d c=%0d cnt=%0d last=%0d iso=%h",
                   exp_r.status, exp_r.group_num, exp_r.city_num, exp_r.spikes,
                   exp_r.last_city, exp_r.iso_row, got.status, got.group_num,
                   got.city_num, got.spikes, got.last_city, got.iso_row);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic [1:0]  kind_i = '0;
  logic [9:0]  neuron_index_i = '0;
  logic [31:0] event_time_i = '0;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         full;
  wire         empty;
  wire  [1:0]  status_o;
  wire  [5:0]  group_number_o;
  wire  [5:0]  city_number_o;
  wire  [15:0] spike_count_o;
  wire  [5:0]  last_city_o;
  wire  [31:0] iso_row_mask_o;
  wire  [31:0] prdata;
  wire         pready;

  route_scoreboard grid_sb = new();
  logic        quiet = 1'b0;
  int unsigned cycles = 0;

  wta_route_exclusion_grid dut (
    .clk_i, .rst_ni, .push, .full, .kind_i, .neuron_index_i, .event_time_i,
    .empty, .pop, .status_o, .group_number_o, .city_number_o, .spike_count_o,
    .last_city_o, .iso_row_mask_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Checks every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      grid_sb.check_result('{wta_pkg::status_e'(status_o), group_number_o, city_number_o,
                             spike_count_o, last_city_o, iso_row_mask_o});
  end

  // Result side: random stall bursts, none once the run goes quiet.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Writes one register through a setup and an access phase.
  task automatic write_reg(logic [3:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits for every outstanding result and for the pipeline to settle.
  task automatic drain();
    push <= 1'b0;
    while (grid_sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Idle point: writes all three registers and mirrors them.
  task automatic configure(logic [5:0] n, logic iso, logic [31:0] we);
    drain();
    write_reg(AddrNumCities, 32'(n));
    write_reg(AddrIsoEnable, 32'(iso));
    write_reg(AddrWindowEnd, we);
    grid_sb.num_cities = n;
    grid_sb.iso_en     = iso;
    grid_sb.win_end    = we;
  endtask

  // Offers one event and waits for its transfer.
  task automatic send_event(wta_pkg::kind_e kind, logic [9:0] idx, logic [31:0] t);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    push           <= 1'b1;
    kind_i         <= kind;
    neuron_index_i <= idx;
    event_time_i   <= t;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    grid_sb.note_event(kind, idx, t);
  endtask

  // Random events biased toward the active grid and the counting window.
  task automatic random_events(int unsigned count);
    int unsigned    n;
    int unsigned    sel;
    wta_pkg::kind_e kind;
    logic [9:0]     idx;
    logic [31:0]    t;
    n = grid_sb.active_cities();
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) kind = wta_pkg::KIND_SPIKE;
      else if (sel < 85) kind = wta_pkg::KIND_REFR;
      else kind = wta_pkg::kind_e'($urandom_range(2, 3));
      if ($urandom_range(0, 99) < 85) idx = 10'($urandom_range(0, n * n - 1));
      else idx = 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 99) < 60)
        t = grid_sb.win_end - 32'($urandom_range(0, 1100)) + 32'd60;
      else t = $urandom;
      send_event(kind, idx, t);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: small grid, isolation on, window ending at 5000.
    configure(6'd4, 1'b1, 32'd5000);
    send_event(wta_pkg::KIND_SPIKE, 10'd5, 32'd4500);   // granted inside the window
    send_event(wta_pkg::KIND_SPIKE, 10'd6, 32'd4500);   // blocked by its row
    send_event(wta_pkg::KIND_SPIKE, 10'd9, 32'd4500);   // blocked by its column
    send_event(wta_pkg::KIND_SPIKE, 10'd5, 32'd4500);   // blocked by itself
    send_event(wta_pkg::KIND_MARK, 10'd5, 32'd0);
    send_event(wta_pkg::KIND_OTHER, 10'd2, 32'hFFFF_FFFF);
    send_event(wta_pkg::KIND_REFR, 10'd5, 32'd0);
    send_event(wta_pkg::KIND_REFR, 10'd5, 32'd0);       // clearing a clear bit
    send_event(wta_pkg::KIND_SPIKE, 10'd0, 32'd5000);   // at the window end, not counted
    send_event(wta_pkg::KIND_REFR, 10'd0, 32'd0);
    send_event(wta_pkg::KIND_SPIKE, 10'd0, 32'd3976);   // at the window start, not counted
    send_event(wta_pkg::KIND_REFR, 10'd0, 32'd0);
    send_event(wta_pkg::KIND_SPIKE, 10'd15, 32'd3977);  // just inside the window
    send_event(wta_pkg::KIND_SPIKE, 10'd16, 32'd4000);  // group beyond the grid
    send_event(wta_pkg::KIND_SPIKE, 10'd1023, 32'hFFFF_FFFF);
    send_event(wta_pkg::KIND_REFR, 10'd1023, 32'd0);
    // Isolation off keeps the old isolation grid.
    configure(6'd4, 1'b0, 32'd0);
    send_event(wta_pkg::KIND_REFR, 10'd15, 32'd0);
    send_event(wta_pkg::KIND_SPIKE, 10'd3, 32'd0);      // window near zero never counts
    send_event(wta_pkg::KIND_MARK, 10'd3, 32'd0);

    // Random phases across the register settings, extremes included.
    configure(6'd2, 1'b1, 32'd1024);
    random_events(100);
    configure(6'd32, 1'b1, 32'hFFFF_FFFF);
    random_events(110);
    configure(6'd0, 1'b1, 32'd3000);                // clamps to two cities
    random_events(80);
    configure(6'd63, 1'b0, 32'h0001_0000);          // clamps to the maximum
    random_events(100);
    configure(6'd7, 1'b1, 32'h8000_0000);
    random_events(60);
    // Sender holds off until every result is back.
    drain();
    random_events(60);
    configure(6'd26, 1'b1, 32'd700);
    random_events(100);
    quiet = 1'b1;
    configure(6'd11, 1'b1, 32'd2048);
    random_events(90);

    drain();
    if (grid_sb.mismatches == 0 && grid_sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
